/* rtl/core/owb_pkg.sv */
// shared types and constants for the 1-wire bus master
`timescale 1ns / 1ps
`default_nettype none

package owb_pkg;

    localparam int COUNT_BITS_DEF = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_REGS       = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_RECOVER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_RECOVER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVER  = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd510;
    localparam logic [CFG_W-1:0] RST_PRES_SAMPLE  = 10'd70;
    localparam logic [CFG_W-1:0] RST_PRES_RECOVER = 10'd430;
    localparam logic [CFG_W-1:0] RST_ZERO_LOW     = 10'd70;
    localparam logic [CFG_W-1:0] RST_ZERO_RECOVER = 10'd5;
    localparam logic [CFG_W-1:0] RST_ONE_LOW      = 10'd10;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE  = 10'd5;
    localparam logic [CFG_W-1:0] RST_READ_RECOVER = 10'd55;

    // mode codes on the input
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_RESET = 3'd1;
    localparam logic [2:0] MODE_BIT   = 3'd2;
    localparam logic [2:0] MODE_BYTE  = 3'd3;
    localparam logic [2:0] MODE_READ2 = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_RESET,
        CMD_BIT,
        CMD_BYTE,
        CMD_READ2
    } cmd_t;

    typedef enum logic [1:0] {
        OPK_RESET = 2'd0,
        OPK_BIT   = 2'd1,
        OPK_BYTE  = 2'd2,
        OPK_READ2 = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        DRV_REL  = 2'd0,
        DRV_LOW  = 2'd1,
        DRV_HIGH = 2'd2
    } drive_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_PULSE,
        PH_RST_WAIT,
        PH_RST_RECOV,
        PH_Z_LOW,
        PH_Z_PULSE,
        PH_Z_REC,
        PH_R_LOW,
        PH_R_PULSE,
        PH_R_WAIT,
        PH_R_REC,
        PH_NEXT
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       lvl;
    } item_t;

    // packed so that bus_drive sits in the lowest bits
    typedef struct packed {
        logic       short_found;
        logic [7:0] value;
        logic       done_res;
        logic       busy_res;
        drive_t     bus_drive;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

/* rtl/core/owb_front.sv */
// front end: command decode and a two-entry item queue
`timescale 1ns / 1ps
`default_nettype none

module owb_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [2:0]     mode,
    input  wire logic [7:0]     data,
    input  wire logic           line_level,
    output logic                q_valid,
    output owb_pkg::item_t      q_item,
    input  wire logic           q_pop
);
    import owb_pkg::*;

    item_t      mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;
    item_t      in_item;

    always_comb
    begin
        case (mode)
            MODE_RESET: in_item.cmd = CMD_RESET;
            MODE_BIT:   in_item.cmd = CMD_BIT;
            MODE_BYTE:  in_item.cmd = CMD_BYTE;
            MODE_READ2: in_item.cmd = CMD_READ2;
            default:    in_item.cmd = CMD_TICK;
        endcase
        in_item.data = data;
        in_item.lvl  = line_level;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/owb_back.sv */
// back end: slot timing state machine, timing registers and result register
`timescale 1ns / 1ps
`default_nettype none

module owb_back #(
    parameter int COUNT_BITS = owb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [owb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [owb_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          q_valid,
    input  wire owb_pkg::item_t                q_item,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output owb_pkg::res_t                      m_res
);
    import owb_pkg::*;

    localparam int MW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [MW-1:0] CNT_MAX = MW'({COUNT_BITS{1'b1}});

    logic [CFG_W-1:0]      cfg_reg [NUM_REGS];
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_reg, tick_next;
    op_kind_t              op_reg, op_next;
    logic [2:0]            bit_idx_reg, bit_idx_next;
    logic [7:0]            send_reg, send_next;
    logic [7:0]            gath_reg, gath_next;
    drive_t                drive_reg, drive_next;
    logic                  short_reg, short_next;
    logic                  step;
    logic                  done;
    logic [7:0]            value;
    logic                  pulse_end;
    logic [2:0]            last_idx;
    logic                  slot_bit;
    logic [7:0]            bits;
    res_t                  res;

    // n ticks including the entering beat, zero counts as one, saturating
    function automatic logic [COUNT_BITS-1:0] load_count(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] v;
        logic [MW-1:0]    ve;
        v  = (n == '0) ? '0 : n - CFG_W'(1);
        ve = MW'(v);
        return (ve > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(ve);
    endfunction

    assign step  = q_valid && (!m_tvalid || m_tready);
    assign q_pop = step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RESET_LOW]    <= RST_RESET_LOW;
            cfg_reg[REG_PRES_SAMPLE]  <= RST_PRES_SAMPLE;
            cfg_reg[REG_PRES_RECOVER] <= RST_PRES_RECOVER;
            cfg_reg[REG_ZERO_LOW]     <= RST_ZERO_LOW;
            cfg_reg[REG_ZERO_RECOVER] <= RST_ZERO_RECOVER;
            cfg_reg[REG_ONE_LOW]      <= RST_ONE_LOW;
            cfg_reg[REG_READ_SAMPLE]  <= RST_READ_SAMPLE;
            cfg_reg[REG_READ_RECOVER] <= RST_READ_RECOVER;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            op_reg      <= OPK_RESET;
            bit_idx_reg <= 3'd0;
            send_reg    <= 8'd0;
            gath_reg    <= 8'd0;
            drive_reg   <= DRV_REL;
            short_reg   <= 1'b0;
            m_tvalid    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                op_reg      <= op_next;
                bit_idx_reg <= bit_idx_next;
                send_reg    <= send_next;
                gath_reg    <= gath_next;
                drive_reg   <= drive_next;
                short_reg   <= short_next;
                m_tvalid    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_res <= res;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        op_next      = op_reg;
        bit_idx_next = bit_idx_reg;
        send_next    = send_reg;
        gath_next    = gath_reg;
        drive_next   = drive_reg;
        short_next   = short_reg;
        done         = 1'b0;
        value        = 8'd0;
        pulse_end    = 1'b0;
        slot_bit     = 1'b0;
        bits         = 8'd0;
        last_idx     = 3'd0;

        if (phase_reg == PH_IDLE)
        begin
            case (q_item.cmd)
                CMD_RESET:
                begin
                    op_next    = OPK_RESET;
                    gath_next  = 8'd0;
                    short_next = 1'b0;
                    if (!q_item.lvl)
                    begin
                        short_next = 1'b1;
                        drive_next = DRV_LOW;
                        done       = 1'b1;
                        value      = 8'd1;
                    end
                    else
                    begin
                        phase_next = PH_RST_LOW;
                        tick_next  = load_count(cfg_reg[REG_RESET_LOW]);
                        drive_next = DRV_LOW;
                    end
                end
                CMD_BIT, CMD_BYTE, CMD_READ2:
                begin
                    case (q_item.cmd)
                        CMD_BIT:
                        begin
                            op_next = OPK_BIT;
                            bits    = {7'd0, q_item.data[0]};
                        end
                        CMD_BYTE:
                        begin
                            op_next = OPK_BYTE;
                            bits    = q_item.data;
                        end
                        default:
                        begin
                            op_next = OPK_READ2;
                            bits    = 8'hFF;
                        end
                    endcase
                    send_next    = bits;
                    bit_idx_next = 3'd0;
                    gath_next    = 8'd0;
                    short_next   = 1'b0;
                    slot_bit     = bits[0];
                    drive_next   = DRV_LOW;
                    if (slot_bit)
                    begin
                        phase_next = PH_R_LOW;
                        tick_next  = load_count(cfg_reg[REG_ONE_LOW]);
                    end
                    else
                    begin
                        phase_next = PH_Z_LOW;
                        tick_next  = load_count(cfg_reg[REG_ZERO_LOW]);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (tick_reg != '0)
        begin
            tick_next = tick_reg - COUNT_BITS'(1);
        end
        else
        begin
            case (phase_reg)
                PH_RST_LOW, PH_Z_LOW, PH_R_LOW:
                begin
                    phase_next = (phase_reg == PH_RST_LOW) ? PH_RST_PULSE :
                                 (phase_reg == PH_Z_LOW)   ? PH_Z_PULSE : PH_R_PULSE;
                    tick_next  = load_count(CFG_W'(1));
                    drive_next = DRV_HIGH;
                end
                PH_RST_PULSE:
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = load_count(cfg_reg[REG_PRES_SAMPLE]);
                    drive_next = DRV_REL;
                end
                PH_RST_WAIT:
                begin
                    gath_next  = {7'd0, q_item.lvl};
                    phase_next = PH_RST_RECOV;
                    tick_next  = load_count(cfg_reg[REG_PRES_RECOVER]);
                    drive_next = DRV_REL;
                end
                PH_RST_RECOV:
                begin
                    phase_next = PH_IDLE;
                    drive_next = DRV_REL;
                    pulse_end  = 1'b1;
                    done       = 1'b1;
                    value      = {7'd0, gath_reg[0]};
                end
                PH_Z_PULSE:
                begin
                    phase_next = PH_Z_REC;
                    tick_next  = load_count(cfg_reg[REG_ZERO_RECOVER]);
                    drive_next = DRV_REL;
                end
                PH_R_PULSE:
                begin
                    phase_next = PH_R_WAIT;
                    tick_next  = load_count(cfg_reg[REG_READ_SAMPLE]);
                    drive_next = DRV_REL;
                end
                PH_R_WAIT:
                begin
                    gath_next[bit_idx_reg] = gath_reg[bit_idx_reg] | q_item.lvl;
                    phase_next = PH_R_REC;
                    tick_next  = load_count(cfg_reg[REG_READ_RECOVER]);
                    drive_next = DRV_REL;
                end
                PH_Z_REC, PH_R_REC:
                begin
                    drive_next = DRV_HIGH;
                    case (op_reg)
                        OPK_BYTE:  last_idx = 3'd7;
                        OPK_READ2: last_idx = 3'd1;
                        default:   last_idx = 3'd0;
                    endcase
                    if (bit_idx_reg >= last_idx)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        value      = gath_reg;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                        phase_next   = PH_NEXT;
                        tick_next    = '0;
                    end
                end
                PH_NEXT:
                begin
                    slot_bit   = send_reg[bit_idx_reg];
                    drive_next = DRV_LOW;
                    if (slot_bit)
                    begin
                        phase_next = PH_R_LOW;
                        tick_next  = load_count(cfg_reg[REG_ONE_LOW]);
                    end
                    else
                    begin
                        phase_next = PH_Z_LOW;
                        tick_next  = load_count(cfg_reg[REG_ZERO_LOW]);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res.bus_drive   = pulse_end ? DRV_HIGH : drive_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.value       = value;
        res.short_found = short_next;
    end

    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (m_res.busy_res == (phase_reg != PH_IDLE)))
        else $error("busy flag out of step with phase");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.done_res) |-> !m_res.busy_res)
        else $error("done reported while still busy");

    a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_res.done_res) |-> (m_res.value == 8'd0))
        else $error("value nonzero without done");

    a_single_bit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OPK_BIT) |-> (bit_idx_reg == 3'd0))
        else $error("single bit slot advanced its bit index");

    a_read2_index: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OPK_READ2) |-> (bit_idx_reg <= 3'd1))
        else $error("two-bit read ran past its second bit");

endmodule

`default_nettype wire

/* rtl/core/one_wire_bus_master.sv */
// top level of the 1-wire bus master
//
//  port group   dir   width   beat contents
//  s_*          in    16+3    tdata: data[7:0], line_level[8]; tuser: mode[2:0]
//  m_*          out   16      tdata: bus_drive[1:0], busy_res[2], done_res[3],
//                             value[11:4], short_found[12]
//  cfg_*        in    3+10    write enable, register index, register value
//
//  one input beat gives exactly one result beat, one per cycle sustained with m_tready high
//  back end steps once per cycle with an item queued and its result register free or taken
//  an input beat reaches the result beat through the queue and the result register
//  a two-entry queue keeps input beats flowing while a result waits on m_tready
//  reset clears the queue, the phase machine and restores the timing registers
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master #(
    parameter int COUNT_BITS = owb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // data, line_level
    input  wire logic [2:0]                    s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,  // bus_drive, busy_res, done_res,
                                                         // value, short_found
    input  wire logic                          cfg_we,
    input  wire logic [owb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [owb_pkg::CFG_W-1:0]     cfg_data
);
    import owb_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    res_t  m_res;

    owb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .mode       (s_tuser),
        .data       (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    owb_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {(16 - RES_W)'(0), m_res};

endmodule

`default_nettype wire
